// File: rtl/ttf_pkg.sv
// ----------------------------------------------------------------------------
// ttf_pkg
// shared types, widths and constants of the taylor trig function unit
// ----------------------------------------------------------------------------
`default_nettype none

package ttf_pkg;

	localparam int FRAC_W      = 24;            // fraction bits of internal values
	localparam int DMAG_W      = 25;            // angle magnitude, q16 degrees
	localparam int AX_W        = 27;            // |x| in q24 radians
	localparam int X2_W        = 30;            // x^2 in q24
	localparam int TERM_W      = 30;            // series term magnitude
	localparam int TQ_W        = 36;            // term product before the divide
	localparam int CD_W        = 9;             // constant series divisor
	localparam int CR_SHIFT    = TQ_W + CD_W;   // scale of the divisor reciprocal
	localparam int CR_W        = CR_SHIFT;      // reciprocal width
	localparam int CR_LO_W     = 23;            // low reciprocal slice
	localparam int CR_HI_W     = CR_W - CR_LO_W;
	localparam int SUM_W       = 34;            // signed series sum
	localparam int MAG_W       = 30;            // operand magnitude of the final divide
	localparam int PM_W        = MAG_W - 7;     // plain q16 magnitude
	localparam int DVD_W       = MAG_W + 17;    // dividend of the final divide
	localparam int RES_W       = 32;
	localparam int ST_W        = 2;

	localparam logic [AX_W-1:0] DEG2RAD_Q32 = 27'd74961321;
	localparam logic signed [SUM_W-1:0] ONE_Q24 = 34'sd16777216;

	typedef enum logic [2:0] {
		KIND_SIN = 3'd0,
		KIND_COS = 3'd1,
		KIND_TAN = 3'd2,
		KIND_COT = 3'd3,
		KIND_SEC = 3'd4,
		KIND_CSC = 3'd5
	} kind_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_DIVZ = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SRC_SIN,
		SRC_COS,
		SRC_ONE
	} src_t;

	typedef enum logic [1:0] {
		OP_PLAIN,
		OP_DIV,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t  op;
		src_t num;
		src_t den;
	} cls_t;

	typedef struct packed {
		logic [DMAG_W-1:0] dmag;
		logic              neg;
		cls_t              cls;
	} job_t;

	typedef struct packed {
		logic neg;
		cls_t cls;
	} sctl_t;

	typedef struct packed {
		op_t             op;
		logic            rneg;
		logic            num_neg;
		logic            dz;
		logic [PM_W-1:0] pmag;
	} fctl_t;

endpackage

`default_nettype wire

// File: rtl/ttf_queue.sv
// ----------------------------------------------------------------------------
// ttf_queue
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
`default_nettype none

module ttf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  empty,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// File: rtl/ttf_front.sv
// ----------------------------------------------------------------------------
// ttf_front
// accepts items, takes the angle magnitude and decodes the function code
// ----------------------------------------------------------------------------
`default_nettype none

module ttf_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic signed [24:0]        angle_degrees,
	input  wire logic        [2:0]         kind,
	output logic                           q_push,
	input  wire logic                      q_full,
	output ttf_pkg::job_t                  q_job
);

	localparam logic [ttf_pkg::DMAG_W:0] WRAP = 26'h2000000;

	logic                        vld_q;
	ttf_pkg::job_t               job_q;
	ttf_pkg::job_t               job_d;
	logic [ttf_pkg::DMAG_W:0]    dmag_ext;

	assign full   = vld_q && q_full;
	assign q_push = vld_q && !q_full;
	assign q_job  = job_q;

	always_comb begin
		dmag_ext = angle_degrees[24] ? (WRAP - {1'b0, angle_degrees}) : {1'b0, angle_degrees};
		job_d.dmag = dmag_ext[ttf_pkg::DMAG_W-1:0];
		job_d.neg  = angle_degrees[24];
		case (kind)
			ttf_pkg::KIND_SIN: job_d.cls = '{ttf_pkg::OP_PLAIN, ttf_pkg::SRC_SIN, ttf_pkg::SRC_ONE};
			ttf_pkg::KIND_COS: job_d.cls = '{ttf_pkg::OP_PLAIN, ttf_pkg::SRC_COS, ttf_pkg::SRC_ONE};
			ttf_pkg::KIND_TAN: job_d.cls = '{ttf_pkg::OP_DIV, ttf_pkg::SRC_SIN, ttf_pkg::SRC_COS};
			ttf_pkg::KIND_COT: job_d.cls = '{ttf_pkg::OP_DIV, ttf_pkg::SRC_COS, ttf_pkg::SRC_SIN};
			ttf_pkg::KIND_SEC: job_d.cls = '{ttf_pkg::OP_DIV, ttf_pkg::SRC_ONE, ttf_pkg::SRC_COS};
			ttf_pkg::KIND_CSC: job_d.cls = '{ttf_pkg::OP_DIV, ttf_pkg::SRC_ONE, ttf_pkg::SRC_SIN};
			default:           job_d.cls = '{ttf_pkg::OP_NONE, ttf_pkg::SRC_ONE, ttf_pkg::SRC_ONE};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (!full) begin
			vld_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (!full) begin
			job_q <= job_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/ttf_back.sv
// ----------------------------------------------------------------------------
// ttf_back
// pipelined series evaluation, final division and result packing
// ----------------------------------------------------------------------------
`default_nettype none

module ttf_back #(
	parameter int SERIES_ORDER = 10
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_empty,
	output logic                                     in_pop,
	input  wire ttf_pkg::job_t                       in_job,
	input  wire logic                                out_full,
	output logic                                     out_valid,
	output logic [ttf_pkg::RES_W-1:0]                out_value,
	output logic [ttf_pkg::ST_W-1:0]                 out_status
);

	localparam int NT    = SERIES_ORDER / 2;
	localparam int P1_W  = ttf_pkg::DMAG_W + ttf_pkg::AX_W;
	localparam int P2_W  = 2 * ttf_pkg::AX_W;
	localparam int PT_W  = ttf_pkg::X2_W + ttf_pkg::TERM_W + 1;
	localparam int FR    = ttf_pkg::FRAC_W;
	localparam int SW    = ttf_pkg::SUM_W;
	localparam int MW    = ttf_pkg::MAG_W;
	localparam int DW    = ttf_pkg::DVD_W;
	localparam int CRW   = ttf_pkg::CR_W;
	localparam int CLW   = ttf_pkg::CR_LO_W;
	localparam int PL_W  = ttf_pkg::TQ_W + CLW;
	localparam int PH_W  = ttf_pkg::TQ_W + ttf_pkg::CR_HI_W;
	localparam int RP_W  = ttf_pkg::TQ_W + CRW;
	localparam logic [P1_W-1:0] RND1 = P1_W'(1) << (FR - 1);
	localparam logic [P2_W-1:0] RND2 = P2_W'(1) << (FR - 1);
	localparam logic [DW-1:0]   MAXP = DW'(32'h7FFF_FFFF);
	localparam logic [DW-1:0]   MAXN = DW'(33'h0_8000_0000);

	function automatic logic signed [SW-1:0] pick(input ttf_pkg::src_t s,
		input logic signed [SW-1:0] sv, input logic signed [SW-1:0] cv);
		case (s)
			ttf_pkg::SRC_SIN: return sv;
			ttf_pkg::SRC_COS: return cv;
			default:          return ttf_pkg::ONE_Q24;
		endcase
	endfunction

	logic en;
	logic pk_vld_sx;

	assign en        = !(pk_vld_sx && out_full);
	assign in_pop    = en && !in_empty;
	assign out_valid = pk_vld_sx;

	// angle to radians
	logic                         v_s1;
	ttf_pkg::sctl_t               ctl_s1;
	logic [ttf_pkg::AX_W-1:0]     ax_s1;
	logic [P1_W-1:0]              p1;
	logic [P2_W-1:0]              p2;

	assign p1 = P1_W'(in_job.dmag) * P1_W'(ttf_pkg::DEG2RAD_Q32) + RND1;
	assign p2 = P2_W'(ax_s1) * P2_W'(ax_s1) + RND2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= p1[FR +: ttf_pkg::AX_W];
			ctl_s1 <= '{in_job.neg, in_job.cls};
		end
	end

	// per-term boundary registers, index 0 holds x^2 and the first terms
	logic                           bv_s   [0:NT];
	ttf_pkg::sctl_t                 bctl_s [0:NT];
	logic [ttf_pkg::X2_W-1:0]       bx2_s  [0:NT];
	logic [ttf_pkg::TERM_W-1:0]     bts_s  [0:NT];
	logic [ttf_pkg::TERM_W-1:0]     btc_s  [0:NT];
	logic signed [SW-1:0]           bss_s  [0:NT];
	logic signed [SW-1:0]           bsc_s  [0:NT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bv_s[0] <= 1'b0;
		end else if (en) begin
			bv_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bctl_s[0] <= ctl_s1;
			bx2_s[0]  <= p2[FR +: ttf_pkg::X2_W];
			bts_s[0]  <= ttf_pkg::TERM_W'(ax_s1);
			btc_s[0]  <= ttf_pkg::TERM_W'(ttf_pkg::ONE_Q24);
			bss_s[0]  <= $signed(SW'(ax_s1));
			bsc_s[0]  <= ttf_pkg::ONE_Q24;
		end
	end

	for (genvar k = 0; k < NT; k++) begin : g_term
		localparam int I = 2 * (k + 1);
		localparam logic [ttf_pkg::CD_W-1:0] DSIN = ttf_pkg::CD_W'((I + 1) * I);
		localparam logic [ttf_pkg::CD_W-1:0] DCOS = ttf_pkg::CD_W'(I * (I - 1));
		localparam logic [PT_W-1:0] HSIN = PT_W'(DSIN) << (FR - 1);
		localparam logic [PT_W-1:0] HCOS = PT_W'(DCOS) << (FR - 1);
		// floor(2^CR_SHIFT / d) + 1, exact for every product below 2^TQ_W
		localparam logic [CRW-1:0] MSIN =
			CRW'((64'd1 << ttf_pkg::CR_SHIFT) / 64'(DSIN) + 64'd1);
		localparam logic [CRW-1:0] MCOS =
			CRW'((64'd1 << ttf_pkg::CR_SHIFT) / 64'(DCOS) + 64'd1);
		localparam bit SUB = (k % 2) == 0;

		logic                          dv_s1;
		logic                          dv_s2;
		logic                          dv_s3;
		ttf_pkg::sctl_t                dctl_s1;
		ttf_pkg::sctl_t                dctl_s2;
		ttf_pkg::sctl_t                dctl_s3;
		logic [ttf_pkg::X2_W-1:0]      dx2_s1;
		logic [ttf_pkg::X2_W-1:0]      dx2_s2;
		logic [ttf_pkg::X2_W-1:0]      dx2_s3;
		logic [ttf_pkg::TQ_W-1:0]      dsa_s1;
		logic [ttf_pkg::TQ_W-1:0]      dca_s1;
		logic [PL_W-1:0]               dsl_s2;
		logic [PL_W-1:0]               dcl_s2;
		logic [PH_W-1:0]               dsh_s2;
		logic [PH_W-1:0]               dch_s2;
		logic [ttf_pkg::TERM_W-1:0]    dsq_s3;
		logic [ttf_pkg::TERM_W-1:0]    dcq_s3;
		logic signed [SW-1:0]          dss_s1;
		logic signed [SW-1:0]          dss_s2;
		logic signed [SW-1:0]          dss_s3;
		logic signed [SW-1:0]          dsc_s1;
		logic signed [SW-1:0]          dsc_s2;
		logic signed [SW-1:0]          dsc_s3;
		logic [PT_W-1:0]               ps;
		logic [PT_W-1:0]               pc;
		logic [RP_W-1:0]               rs;
		logic [RP_W-1:0]               rc;
		logic signed [SW-1:0]          qs;
		logic signed [SW-1:0]          qc;

		assign ps = PT_W'(bts_s[k]) * PT_W'(bx2_s[k]) + HSIN;
		assign pc = PT_W'(btc_s[k]) * PT_W'(bx2_s[k]) + HCOS;
		assign rs = RP_W'(dsl_s2) + (RP_W'(dsh_s2) << CLW);
		assign rc = RP_W'(dcl_s2) + (RP_W'(dch_s2) << CLW);
		assign qs = $signed(SW'(dsq_s3));
		assign qc = $signed(SW'(dcq_s3));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s1 <= 1'b0;
				dv_s2 <= 1'b0;
				dv_s3 <= 1'b0;
			end else if (en) begin
				dv_s1 <= bv_s[k];
				dv_s2 <= dv_s1;
				dv_s3 <= dv_s2;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				// term times x^2, rounded to the divisor
				dctl_s1 <= bctl_s[k];
				dx2_s1  <= bx2_s[k];
				dsa_s1  <= ps[FR +: ttf_pkg::TQ_W];
				dca_s1  <= pc[FR +: ttf_pkg::TQ_W];
				dss_s1  <= bss_s[k];
				dsc_s1  <= bsc_s[k];
				// partial products with the divisor reciprocal
				dctl_s2 <= dctl_s1;
				dx2_s2  <= dx2_s1;
				dsl_s2  <= PL_W'(dsa_s1) * PL_W'(MSIN[CLW-1:0]);
				dsh_s2  <= PH_W'(dsa_s1) * PH_W'(MSIN[CRW-1:CLW]);
				dcl_s2  <= PL_W'(dca_s1) * PL_W'(MCOS[CLW-1:0]);
				dch_s2  <= PH_W'(dca_s1) * PH_W'(MCOS[CRW-1:CLW]);
				dss_s2  <= dss_s1;
				dsc_s2  <= dsc_s1;
				// quotient
				dctl_s3 <= dctl_s2;
				dx2_s3  <= dx2_s2;
				dsq_s3  <= rs[ttf_pkg::CR_SHIFT +: ttf_pkg::TERM_W];
				dcq_s3  <= rc[ttf_pkg::CR_SHIFT +: ttf_pkg::TERM_W];
				dss_s3  <= dss_s2;
				dsc_s3  <= dsc_s2;
			end
		end

		// alternate subtract and add, starting with subtract
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				bv_s[k+1] <= 1'b0;
			end else if (en) begin
				bv_s[k+1] <= dv_s3;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				bctl_s[k+1] <= dctl_s3;
				bx2_s[k+1]  <= dx2_s3;
				bts_s[k+1]  <= dsq_s3;
				btc_s[k+1]  <= dcq_s3;
				bss_s[k+1]  <= SUB ? (dss_s3 - qs) : (dss_s3 + qs);
				bsc_s[k+1]  <= SUB ? (dsc_s3 - qc) : (dsc_s3 + qc);
			end
		end
	end

	// operand select
	logic                  v_f1;
	ttf_pkg::op_t          op_f1;
	logic signed [SW-1:0]  num_f1;
	logic signed [SW-1:0]  den_f1;
	logic signed [SW-1:0]  s_fin;

	assign s_fin = bctl_s[NT].neg ? -bss_s[NT] : bss_s[NT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1 <= 1'b0;
		end else if (en) begin
			v_f1 <= bv_s[NT];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_f1  <= bctl_s[NT].cls.op;
			num_f1 <= pick(bctl_s[NT].cls.num, s_fin, bsc_s[NT]);
			den_f1 <= pick(bctl_s[NT].cls.den, s_fin, bsc_s[NT]);
		end
	end

	// magnitudes, plain rounding and dividend
	logic              nneg;
	logic              dneg;
	logic [SW-1:0]     nabs;
	logic [SW-1:0]     dabs;
	logic [MW-1:0]     nm;
	logic [MW-1:0]     dm;
	logic [MW:0]       prnd;
	ttf_pkg::fctl_t    fctl_d;

	assign nneg = num_f1[SW-1];
	assign dneg = den_f1[SW-1];
	assign nabs = nneg ? SW'(-num_f1) : SW'(num_f1);
	assign dabs = dneg ? SW'(-den_f1) : SW'(den_f1);
	assign nm   = nabs[MW-1:0];
	assign dm   = dabs[MW-1:0];
	assign prnd = (MW+1)'(nm) + (MW+1)'(128);

	always_comb begin
		fctl_d.op      = op_f1;
		fctl_d.rneg    = (op_f1 == ttf_pkg::OP_DIV) ? (nneg ^ dneg) : nneg;
		fctl_d.num_neg = nneg;
		fctl_d.dz      = (dm == '0);
		fctl_d.pmag    = prnd[8 +: ttf_pkg::PM_W];
	end

	// restoring divider, one quotient bit per stage
	logic              qv_s   [0:DW];
	ttf_pkg::fctl_t    qctl_s [0:DW];
	logic [DW-1:0]     qacc_s [0:DW];
	logic [MW-1:0]     qrem_s [0:DW];
	logic [MW-1:0]     qdm_s  [0:DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s[0] <= 1'b0;
		end else if (en) begin
			qv_s[0] <= v_f1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qctl_s[0] <= fctl_d;
			qacc_s[0] <= (DW'(nm) << 16) + DW'(dm >> 1);
			qrem_s[0] <= '0;
			qdm_s[0]  <= dm;
		end
	end

	for (genvar j = 0; j < DW; j++) begin : g_div
		logic [MW:0] r;
		logic [MW:0] rn;
		logic        ge;

		assign r  = {qrem_s[j], qacc_s[j][DW-1]};
		assign ge = r >= {1'b0, qdm_s[j]};
		assign rn = ge ? (r - {1'b0, qdm_s[j]}) : r;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				qv_s[j+1] <= 1'b0;
			end else if (en) begin
				qv_s[j+1] <= qv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				qctl_s[j+1] <= qctl_s[j];
				qacc_s[j+1] <= {qacc_s[j][DW-2:0], ge};
				qrem_s[j+1] <= rn[MW-1:0];
				qdm_s[j+1]  <= qdm_s[j];
			end
		end
	end

	// saturation and packing
	ttf_pkg::fctl_t              fc;
	logic [DW-1:0]               mag;
	logic [ttf_pkg::RES_W-1:0]   val_d;
	logic [ttf_pkg::ST_W-1:0]    st_d;
	logic [ttf_pkg::RES_W-1:0]   pk_val_sx;
	logic [ttf_pkg::ST_W-1:0]    pk_st_sx;

	assign fc  = qctl_s[DW];
	assign mag = (fc.op == ttf_pkg::OP_PLAIN) ? DW'(fc.pmag) : qacc_s[DW];

	always_comb begin
		val_d = '0;
		st_d  = ttf_pkg::ST_OK;
		case (fc.op)
			ttf_pkg::OP_PLAIN, ttf_pkg::OP_DIV: begin
				if (fc.op == ttf_pkg::OP_DIV && fc.dz) begin
					val_d = fc.num_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
					st_d  = ttf_pkg::ST_DIVZ;
				end else if (!fc.rneg && mag > MAXP) begin
					val_d = 32'h7FFF_FFFF;
					st_d  = ttf_pkg::ST_SAT;
				end else if (fc.rneg && mag > MAXN) begin
					val_d = 32'h8000_0000;
					st_d  = ttf_pkg::ST_SAT;
				end else begin
					val_d = fc.rneg ? (32'd0 - mag[31:0]) : mag[31:0];
				end
			end
			default: begin
				val_d = '0;
				st_d  = ttf_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_vld_sx <= 1'b0;
		end else if (en) begin
			pk_vld_sx <= qv_s[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pk_val_sx <= val_d;
			pk_st_sx  <= st_d;
		end
	end

	assign out_value  = pk_val_sx;
	assign out_status = pk_st_sx;

endmodule

`default_nettype wire

// File: rtl/taylor_trig_function_unit_top.sv
// ----------------------------------------------------------------------------
// taylor_trig_function_unit_top
// sine, cosine and derived functions of an angle in degrees by taylor series
// ----------------------------------------------------------------------------
// The unit takes one item per clock while the input side is not full: a
// signed Q8.16 angle in degrees and a function code (sine, cosine, tangent,
// cotangent, secant, cosecant), and returns one Q16.16 result with a status
// for each item, in order. The angle is turned into radians and both series
// are evaluated with no range reduction; quotients are rounded half up on the
// magnitude, overflow saturates (status 1) and a zero divisor saturates with
// status 2; codes 6 and 7 give zero. Throughput is one item per cycle while
// the result side does not stall. On the way an item passes the front
// register, loaded at the accepting edge itself, the middle queue, 2 stages
// for the radian and square multiplies, 4 stages per series term (multiply,
// two stages of multiplying by the divisor's reciprocal, accumulate), 2
// operand stages, 47 stages of the bit-serial quotient divider, a pack stage
// and the output queue. A full output queue holds the whole back pipeline;
// the middle queue then absorbs what the front has taken.
// ----------------------------------------------------------------------------
`default_nettype none

module taylor_trig_function_unit_top #(
	parameter int SERIES_ORDER = 10,
	parameter int MID_DEPTH    = 4,
	parameter int OUT_DEPTH    = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input side
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [24:0] angle_degrees,
	input  wire logic        [2:0]  kind,
	// result side
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [31:0]      result_value,
	output logic        [1:0]       status
);

	localparam int JOB_W = $bits(ttf_pkg::job_t);
	localparam int RES_ITEM_W = ttf_pkg::RES_W + ttf_pkg::ST_W;

	// front to middle queue
	logic              fr_push;
	logic              mid_full;
	ttf_pkg::job_t     fr_job;

	// middle queue to back
	logic              mid_empty;
	logic              mid_pop;
	logic [JOB_W-1:0]  mid_data;
	ttf_pkg::job_t     mid_job;

	// back to output queue
	logic                          bk_valid;
	logic                          out_q_full;
	logic [ttf_pkg::RES_W-1:0]     bk_value;
	logic [ttf_pkg::ST_W-1:0]      bk_status;
	logic [RES_ITEM_W-1:0]         out_data;

	assign mid_job = ttf_pkg::job_t'(mid_data);

	// take the item, fold the angle sign and decode the function
	ttf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.angle_degrees (angle_degrees),
		.kind          (kind),
		.q_push        (fr_push),
		.q_full        (mid_full),
		.q_job         (fr_job)
	);

	// decouples the front from back-pressure on the result side
	ttf_queue #(
		.WIDTH (JOB_W),
		.DEPTH (MID_DEPTH)
	) u_mid_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fr_push),
		.full    (mid_full),
		.wr_data (fr_job),
		.empty   (mid_empty),
		.pop     (mid_pop),
		.rd_data (mid_data)
	);

	// series, division and saturation pipeline
	ttf_back #(
		.SERIES_ORDER (SERIES_ORDER)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_empty   (mid_empty),
		.in_pop     (mid_pop),
		.in_job     (mid_job),
		.out_full   (out_q_full),
		.out_valid  (bk_valid),
		.out_value  (bk_value),
		.out_status (bk_status)
	);

	// result queue, head item drives the result ports
	ttf_queue #(
		.WIDTH (RES_ITEM_W),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (bk_valid),
		.full    (out_q_full),
		.wr_data ({bk_value, bk_status}),
		.empty   (empty),
		.pop     (pop),
		.rd_data (out_data)
	);

	assign result_value = $signed(out_data[RES_ITEM_W-1:ttf_pkg::ST_W]);
	assign status       = out_data[ttf_pkg::ST_W-1:0];

endmodule

`default_nettype wire

// File: rtl/ttf_checker.sv
// ----------------------------------------------------------------------------
// ttf_checker
// port-level checks of the taylor trig function unit
// ----------------------------------------------------------------------------
`default_nettype none

module ttf_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               full,
	input wire logic               empty,
	input wire logic               pop,
	input wire logic signed [31:0] result_value,
	input wire logic        [1:0]  status
);

	// a waiting item stays put until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result_value) && $stable(status))
		else $error("result item changed while stalled");

	// saturation always lands on a range end
	a_sat_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status == ttf_pkg::ST_SAT |->
		result_value == 32'sh7FFF_FFFF || result_value == 32'sh8000_0000)
		else $error("saturated result not at a range end");

	// zero divisor gives a range end as well
	a_divz_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status == ttf_pkg::ST_DIVZ |->
		result_value == 32'sh7FFF_FFFF || result_value == 32'sh8000_0000)
		else $error("division by zero result not at a range end");

	// leaving reset, nothing is waiting and input is open
	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> empty && !full)
		else $error("unit not empty and open after reset");

endmodule

bind taylor_trig_function_unit_top ttf_checker u_checker (.*);

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench of the taylor trig function unit
// ----------------------------------------------------------------------------
// Drives angles and function codes through the input queue in bursts with
// random gaps, pops results with a changing stall pattern, and compares every
// result field by field with a bit-exact fixed-point prediction held in a
// small scoreboard class. One long receiver hold fills the unit up, and the
// sender drains the unit completely more than once.
// ----------------------------------------------------------------------------

module tb;

	localparam int NUM_RANDOM  = 1500;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 200;   // longer than the pipeline latency
	localparam int SERIES_N    = 10;

	typedef struct {
		logic signed [31:0] val;
		ttf_pkg::status_t   st;
	} trig_result_t;

	// expected results in order, and the math that produces them
	class trig_scoreboard;
		trig_result_t waiting[$];
		int           mismatches;
		int           checked;

		function longint series_sum(longint unsigned ax, bit cosine);
			longint unsigned x2, term, d, q;
			longint          sum;
			bit              sub;
			x2   = (ax * ax + 64'd8388608) >> 24;
			term = cosine ? 64'd16777216 : ax;
			sum  = longint'(term);
			sub  = 1'b1;
			for (int i = 2; i <= SERIES_N; i += 2) begin
				d    = cosine ? i * (i - 1) : (i + 1) * i;
				q    = d << 24;
				term = (term * x2 + (q >> 1)) / q;
				if (sub)
					sum -= longint'(term);
				else
					sum += longint'(term);
				sub = !sub;
			end
			return sum;
		endfunction

		function trig_result_t saturate(bit neg, longint unsigned mag);
			trig_result_t r;
			r.st = ttf_pkg::ST_OK;
			if (!neg && mag > 64'h7FFFFFFF) begin
				r.val = 32'h7FFFFFFF;
				r.st  = ttf_pkg::ST_SAT;
			end else if (neg && mag > 64'h80000000) begin
				r.val = 32'h80000000;
				r.st  = ttf_pkg::ST_SAT;
			end else begin
				r.val = neg ? -mag[31:0] : mag[31:0];
			end
			return r;
		endfunction

		function longint unsigned magnitude(longint v);
			return v < 0 ? longint'(-v) : v;
		endfunction

		function trig_result_t plain(longint v);
			return saturate(v < 0, (magnitude(v) + 128) >> 8);
		endfunction

		function trig_result_t quotient(longint num, longint den);
			trig_result_t    r;
			longint unsigned nm, dm;
			nm = magnitude(num);
			dm = magnitude(den);
			if (dm == 0) begin
				r.val = num < 0 ? 32'h80000000 : 32'h7FFFFFFF;
				r.st  = ttf_pkg::ST_DIVZ;
				return r;
			end
			return saturate((num < 0) != (den < 0), ((nm << 16) + (dm >> 1)) / dm);
		endfunction

		// an item went in: work out what must come out for it
		function void note(logic signed [24:0] angle, logic [2:0] k);
			longint unsigned dmag, ax;
			longint          s, c;
			trig_result_t    r;
			dmag = angle < 0 ? 64'(-longint'(angle)) : 64'(angle);
			ax   = (dmag * 64'd74961321 + 64'd8388608) >> 24;
			s    = series_sum(ax, 1'b0);
			c    = series_sum(ax, 1'b1);
			if (angle < 0)
				s = -s;
			case (k)
				ttf_pkg::KIND_SIN: r = plain(s);
				ttf_pkg::KIND_COS: r = plain(c);
				ttf_pkg::KIND_TAN: r = quotient(s, c);
				ttf_pkg::KIND_COT: r = quotient(c, s);
				ttf_pkg::KIND_SEC: r = quotient(64'd16777216, c);
				ttf_pkg::KIND_CSC: r = quotient(64'd16777216, s);
				default: begin
					r.val = '0;
					r.st  = ttf_pkg::ST_OK;
				end
			endcase
			waiting.push_back(r);
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $time, what);
			mismatches++;
		endtask

		// a result came out: compare it with the oldest expectation
		task check(logic signed [31:0] val, logic [1:0] st);
			trig_result_t e;
			if (waiting.size() == 0) begin
				report($sformatf("unexpected result %h status %0d", val, st));
				return;
			end
			e = waiting.pop_front();
			checked++;
			if (val !== e.val)
				report($sformatf("result_value %h, predicted %h", val, e.val));
			if (st !== e.st)
				report($sformatf("status %0d, predicted %0d", st, e.st));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic signed [24:0] angle_degrees;
	logic        [2:0]  kind;
	logic               empty;
	logic               pop;
	logic signed [31:0] result_value;
	logic        [1:0]  status;

	trig_scoreboard sb;
	int             cycle_count;
	int             items_sent;
	int             div_zero_seen;
	int             sat_seen;

	taylor_trig_function_unit_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.angle_degrees (angle_degrees),
		.kind          (kind),
		.empty         (empty),
		.pop           (pop),
		.result_value  (result_value),
		.status        (status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// both handshakes are observed here, before the unit updates its outputs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (push && !full) begin
			sb.note(angle_degrees, kind);
			items_sent <= items_sent + 1;
		end
		if (pop && !empty) begin
			if (status == ttf_pkg::ST_DIVZ)
				div_zero_seen <= div_zero_seen + 1;
			if (status == ttf_pkg::ST_SAT)
				sat_seen <= sat_seen + 1;
			sb.check(result_value, status);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending",
				cycle_count, sb.waiting.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// offer one item and hold it until the unit takes it
	task send_item(input logic signed [24:0] a, input logic [2:0] k);
		@(negedge clk);
		push          <= 1'b1;
		angle_degrees <= a;
		kind          <= k;
		do @(posedge clk); while (full);
	endtask

	task idle_sender(input int cycles);
		@(negedge clk);
		push <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task wait_drained;
		idle_sender(1);
		while (sb.waiting.size() != 0)
			@(posedge clk);
	endtask

	// random angle: mostly the stated range, some near the quadrant points,
	// some any 25-bit pattern
	function automatic logic signed [24:0] pick_angle;
		int sel;
		int quad;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return 25'($signed($urandom_range(0, 2 * 11796480)) - 11796480);
		if (sel < 9) begin
			quad = $urandom_range(0, 4) - 2;
			return 25'(quad * 90 * 65536 + $signed($urandom_range(0, 8)) - 4);
		end
		return 25'($urandom);
	endfunction

	// receiver: changing stall pattern, with one long hold
	// early in the random phase while the sender keeps offering
	initial begin
		int rc;
		int mode;
		int hold_left;
		rc        = 0;
		mode      = 0;
		hold_left = 0;
		pop       = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rc++;
			if (rc == 800)
				hold_left = 500;
			if (rc % 64 == 0)
				mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case (mode)
					0:       pop <= 1'b1;
					1:       pop <= ($urandom_range(0, 1) == 1);
					2:       pop <= ($urandom_range(0, 3) == 0);
					default: pop <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin
		logic signed [24:0] corner [8];
		int                 left;
		sb            = new();
		cycle_count   = 0;
		items_sent    = 0;
		div_zero_seen = 0;
		sat_seen      = 0;
		arst_n        = 1'b0;
		push          = 1'b0;
		angle_degrees = '0;
		kind          = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every code at zero (zero sine divides), then corners
		for (int k = 0; k < 8; k++)
			send_item(25'sd0, 3'(k));
		corner[0] = 25'sd11796480;        // +180
		corner[1] = -25'sd11796480;       // -180
		corner[2] = 25'sh0FFFFFF;         // largest pattern
		corner[3] = 25'sh1000000;         // most negative pattern
		corner[4] = 25'sd5898240;         // +90
		corner[5] = -25'sd5898240;        // -90
		corner[6] = 25'sd1;
		corner[7] = -25'sd1;
		for (int n = 0; n < 8; n++) begin
			send_item(corner[n], ttf_pkg::KIND_TAN);
			send_item(corner[n], 3'(n < 6 ? n : 7 - n + 4));
		end
		wait_drained();

		// random bursts with random gaps
		left = NUM_RANDOM;
		while (left > 0) begin
			for (int b = $urandom_range(1, 40); b > 0 && left > 0; b--) begin
				send_item(pick_angle(), 3'($urandom_range(0, 7)));
				left--;
				if (left == NUM_RANDOM / 2)
					wait_drained();
			end
			if ($urandom_range(0, 3) != 0)
				idle_sender($urandom_range(1, 20));
		end
		idle_sender(1);

		while (sb.waiting.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d items, %0d results checked (%0d zero divisors, %0d saturated)",
			items_sent, sb.checked, div_zero_seen, sat_seen);
		$display("receiver hold filled the unit, sender drained it twice");
		if (sb.mismatches == 0 && sb.waiting.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
